>>> sv/tcw_pkg.sv
// shared constants and types for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int OP_W   = 2;

  // tab stops every eight columns
  localparam int TAB_BITS = 3;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TAB,
    ST_SCROLL,
    ST_FILL,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

>>> sv/tcw_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/text_console_writer.sv
// text console writer: cursor control and character cell store
`timescale 1ns / 1ps
`default_nettype none

// Character-cell text console with a COLUMNS x ROWS screen held in one memory.
// After reset busy stays high while every cell is written with a blank of
// attribute 7. The attribute register takes a write only while busy is low and
// no command is being started.
// A command is taken when start is high and busy low.
// Printable characters, carriage return, backspace and a newline that does not
// scroll finish in the state that takes them; a read adds ST_READ for the memory
// read. A tab writes one space per cycle, up to eight. A clear writes a blank of
// the current attribute to every cell. A scroll adds a row copy and a blank fill
// of the last row, one cell per cycle through the single memory write port. Every
// command gives one word on out_valid in the cycle after it finishes; the
// receiver cannot hold it off, and the cursor shown is the cursor after the
// command.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS),
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tcw_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  wire logic [ADDR_W-1:0]           in_cell_index,
  output logic                             out_valid,
  output logic [COL_W-1:0]                 out_cursor_column,
  output logic [ROW_W-1:0]                 out_cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]       out_cell_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_text_attribute
);

  localparam int SHIFT_CELLS = CELLS - COLUMNS;

  tcw_pkg::state_t state_r, state_nxt;

  logic [COL_W-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [ADDR_W-1:0]          k_r, k_nxt;
  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0] cell_r, cell_nxt;
  logic                       read_ok_r, read_ok_nxt;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  logic                       accept;
  logic [ADDR_W-1:0]          pos;
  logic [tcw_pkg::CHAR_W-1:0] put_ch;
  logic [COL_W:0]             col_inc;
  logic [ROW_W:0]             row_inc;
  logic                       wrap;
  logic                       row_over;
  logic                       put_over;
  logic [COL_W-1:0]           put_col;
  logic [ROW_W-1:0]           put_row;
  logic                       tab_more;
  logic                       fill_last;
  logic                       shift_last;
  logic [tcw_pkg::CELL_W-1:0] blank_cell;

  // shared put-character step, command accept and fill/scroll end tests
  always_comb begin
    accept     = start && (state_r == tcw_pkg::ST_IDLE);
    pos        = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
    put_ch     = (state_r == tcw_pkg::ST_TAB || in_char_code == tcw_pkg::CH_TAB)
                 ? tcw_pkg::BLANK_CHAR : in_char_code;
    col_inc    = (COL_W+1)'(col_r) + (COL_W+1)'(1);
    row_inc    = (ROW_W+1)'(row_r) + (ROW_W+1)'(1);
    wrap       = col_inc == (COL_W+1)'(COLUMNS);
    row_over   = row_inc == (ROW_W+1)'(ROWS);
    put_over   = wrap && row_over;
    put_col    = wrap ? '0 : col_inc[COL_W-1:0];
    put_row    = (wrap && !row_over) ? row_inc[ROW_W-1:0] : row_r;
    tab_more   = put_col[tcw_pkg::TAB_BITS-1:0] != '0;
    fill_last  = k_r == ADDR_W'(CELLS - 1);
    shift_last = k_r == ADDR_W'(SHIFT_CELLS);
    blank_cell = {attr_r, tcw_pkg::BLANK_CHAR};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (fill_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            tcw_pkg::OP_PUT: begin
              unique case (in_char_code)
                tcw_pkg::CH_LF: begin
                  if (row_over) begin
                    state_nxt = tcw_pkg::ST_SCROLL;
                  end
                end
                tcw_pkg::CH_CR, tcw_pkg::CH_BS: begin
                  state_nxt = tcw_pkg::ST_IDLE;
                end
                tcw_pkg::CH_TAB: begin
                  if (put_over) begin
                    state_nxt = tcw_pkg::ST_SCROLL;
                  end else if (tab_more) begin
                    state_nxt = tcw_pkg::ST_TAB;
                  end
                end
                default: begin
                  if (put_over) begin
                    state_nxt = tcw_pkg::ST_SCROLL;
                  end
                end
              endcase
            end
            tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_FILL;
            tcw_pkg::OP_READ:  state_nxt = tcw_pkg::ST_READ;
            default:           state_nxt = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_TAB: begin
        if (put_over) begin
          state_nxt = tcw_pkg::ST_SCROLL;
        end else if (!tab_more) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (shift_last) begin
          state_nxt = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        if (fill_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_IDLE;
      default:          state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    cell_nxt      = '0;
    read_ok_nxt   = read_ok_r;
    mem_we        = 1'b0;
    mem_waddr     = pos;
    mem_wdata     = {attr_r, put_ch};
    mem_re        = 1'b0;
    mem_raddr     = in_cell_index;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
        k_nxt     = fill_last ? '0 : k_r + ADDR_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          k_nxt = '0;
          unique case (in_opcode)
            tcw_pkg::OP_PUT: begin
              unique case (in_char_code)
                tcw_pkg::CH_LF: begin
                  col_nxt       = '0;
                  row_nxt       = row_over ? row_r : row_inc[ROW_W-1:0];
                  out_valid_nxt = !row_over;
                end
                tcw_pkg::CH_CR: begin
                  col_nxt       = '0;
                  out_valid_nxt = 1'b1;
                end
                tcw_pkg::CH_BS: begin
                  if (col_r != '0) begin
                    col_nxt   = col_r - COL_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = pos - ADDR_W'(1);
                    mem_wdata = blank_cell;
                  end
                  out_valid_nxt = 1'b1;
                end
                tcw_pkg::CH_TAB: begin
                  mem_we        = 1'b1;
                  col_nxt       = put_col;
                  row_nxt       = put_row;
                  out_valid_nxt = !put_over && !tab_more;
                end
                default: begin
                  mem_we        = 1'b1;
                  col_nxt       = put_col;
                  row_nxt       = put_row;
                  out_valid_nxt = !put_over;
                end
              endcase
            end
            tcw_pkg::OP_CLEAR: begin
              k_nxt = '0;
            end
            tcw_pkg::OP_READ: begin
              read_ok_nxt = {1'b0, in_cell_index} < (ADDR_W+1)'(CELLS);
              mem_re      = read_ok_nxt;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_TAB: begin
        mem_we        = 1'b1;
        col_nxt       = put_col;
        row_nxt       = put_row;
        k_nxt         = '0;
        out_valid_nxt = !put_over && !tab_more;
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write the word read in the previous cycle
        mem_re    = !shift_last;
        mem_raddr = k_r + ADDR_W'(COLUMNS);
        mem_we    = k_r != '0;
        mem_waddr = k_r - ADDR_W'(1);
        mem_wdata = mem_rdata;
        k_nxt     = shift_last ? k_r : k_r + ADDR_W'(1);
      end
      tcw_pkg::ST_FILL: begin
        mem_we        = 1'b1;
        mem_waddr     = k_r;
        mem_wdata     = blank_cell;
        k_nxt         = fill_last ? '0 : k_r + ADDR_W'(1);
        out_valid_nxt = fill_last;
      end
      tcw_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        cell_nxt      = read_ok_r ? mem_rdata : '0;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      k_r         <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    cell_r    <= cell_nxt;
    read_ok_r <= read_ok_nxt;
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy              = state_r != tcw_pkg::ST_IDLE;
  assign cfg_ready         = !busy && !start;
  assign out_valid         = out_valid_r;
  assign out_cursor_column = col_r;
  assign out_cursor_row    = row_r;
  assign out_cell_value    = cell_r;

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (COL_W+1)'(col_r) < (COL_W+1)'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ROW_W+1)'(row_r) < (ROW_W+1)'(ROWS))
    else $error("cursor row out of range");

  a_scroll_read_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_SCROLL && k_r != '0) |-> $past(mem_re))
    else $error("scroll write without a read one cycle before");

  a_word_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == tcw_pkg::ST_IDLE)
    else $error("result word while a command is still running");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_READ) |-> !mem_we)
    else $error("memory write during a cell read");
`endif

endmodule

`default_nettype wire

>>> tb/tcw_scoreboard_pkg.sv
// text console scoreboard: screen and cursor prediction with result checking
`timescale 1ns / 1ps

package tcw_scoreboard_pkg;

  import tcw_pkg::*;

  localparam int COLS     = COLUMNS_DEF;
  localparam int ROWS     = ROWS_DEF;
  localparam int CELLS    = COLS * ROWS;
  localparam int COL_W    = $clog2(COLS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int TAB_STOP = 1 << TAB_BITS;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_value;
  } console_word_t;

  class console_scoreboard;
    logic [ATTR_W-1:0] attr;
    int cur_col;
    int cur_row;
    logic [CELL_W-1:0] screen [CELLS];
    console_word_t expected_words[$];
    int mismatches;

    function new();
      attr = RESET_ATTR;
      cur_col = 0;
      cur_row = 0;
      mismatches = 0;
      fill_blank();
    endfunction

    function logic [CELL_W-1:0] blank_cell();
      return {attr, BLANK_CHAR};
    endfunction

    function void fill_blank();
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
    endfunction

    function void set_attr(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    // column wrap, then scroll while the cursor is below the last row
    function void settle();
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
      while (cur_row >= ROWS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = blank_cell();
        cur_row--;
      end
    endfunction

    function void place(logic [CHAR_W-1:0] ch);
      screen[cur_row * COLS + cur_col] = {attr, ch};
      cur_col++;
      settle();
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic [ADDR_W-1:0] idx);
      console_word_t want;
      want.cell_value = '0;
      case (op)
        OP_PUT: begin
          case (ch)
            CH_LF: begin
              cur_col = 0;
              cur_row++;
              settle();
            end
            CH_CR: cur_col = 0;
            CH_BS: begin
              if (cur_col > 0) begin
                cur_col--;
                screen[cur_row * COLS + cur_col] = blank_cell();
              end
            end
            CH_TAB: begin
              do place(BLANK_CHAR); while ((cur_col % TAB_STOP) != 0);
            end
            default: place(ch);
          endcase
        end
        OP_CLEAR: fill_blank();
        OP_READ: begin
          if (idx < CELLS) want.cell_value = screen[idx];
        end
        default: ;
      endcase
      want.column = COL_W'(cur_col);
      want.row = ROW_W'(cur_row);
      expected_words.push_back(want);
    endfunction

    function void check_word(logic [COL_W-1:0] column, logic [ROW_W-1:0] row,
                             logic [CELL_W-1:0] value);
      console_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word col=%0d row=%0d value=%h",
                   column, row, value);
        return;
      end
      want = expected_words.pop_front();
      if (column !== want.column || row !== want.row || value !== want.cell_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected col=%0d row=%0d value=%h, got col=%0d row=%0d value=%h",
                   want.column, want.row, want.cell_value, column, row, value);
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// testbench top for the text console writer
`timescale 1ns / 1ps

module tb_top;

  import tcw_pkg::*;
  import tcw_scoreboard_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_opcode = OP_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ADDR_W-1:0] in_cell_index = '0;
  logic out_valid;
  logic [COL_W-1:0] out_cursor_column;
  logic [ROW_W-1:0] out_cursor_row;
  logic [CELL_W-1:0] out_cell_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ATTR_W-1:0] cfg_text_attribute = '0;

  console_scoreboard sb;
  int burst_left = 0;

  text_console_writer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_cell_value     (out_cell_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_text_attribute (cfg_text_attribute)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_cursor_column, out_cursor_row, out_cell_value);
  end

  task automatic send_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_opcode <= op;
    in_char_code <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_command(op, ch, idx);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0 || busy);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_text_attribute <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_attr(value);
  endtask

  // one item of running text; planned line feeds only come at line ends, though a random byte may be one
  task automatic send_text_item();
    int pick;
    int row_pick;
    logic [OP_W-1:0] op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
    pick = $urandom_range(0, 99);
    op = OP_PUT;
    ch = CHAR_W'($urandom);
    idx = ADDR_W'($urandom);
    if (pick < 65) begin
      if (pick < 55) ch = CHAR_W'($urandom_range(32, 126));
    end else if (pick < 70) ch = CH_TAB;
    else if (pick < 73) ch = CH_BS;
    else if (pick < 75) ch = CH_CR;
    else if (pick < 95) begin
      op = OP_READ;
      row_pick = sb.cur_row - $urandom_range(0, (sb.cur_row > 2) ? 2 : sb.cur_row);
      idx = ADDR_W'(row_pick * COLS + $urandom_range(0, COLS - 1));
    end else if (pick < 96) op = OP_CLEAR;
    else if (pick < 98) op = OP_UNUSED;
    else op = OP_READ;
    send_command(op, ch, idx);
  endtask

  task automatic send_text(input int count);
    int sent;
    int line_len;
    sent = 0;
    while (sent < count) begin
      line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 12);
      repeat (line_len) begin
        send_text_item();
        sent++;
      end
      send_command(OP_PUT, CH_LF, ADDR_W'($urandom));
      sent++;
    end
  endtask

  initial begin
    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    // reset contents, last cell, reads past the end
    send_command(OP_READ, 8'h00, ADDR_W'(0));
    send_command(OP_READ, 8'hff, ADDR_W'(CELLS - 1));
    send_command(OP_READ, 8'h00, ADDR_W'(CELLS));
    send_command(OP_READ, 8'h00, '1);
    // byte extremes, read back with the attribute in the high byte
    send_command(OP_PUT, 8'h41, '1);
    send_command(OP_PUT, 8'h00, '0);
    send_command(OP_PUT, 8'hff, '0);
    send_command(OP_PUT, 8'h80, '0);
    send_command(OP_READ, 8'h00, ADDR_W'(2));
    send_command(OP_READ, 8'h00, ADDR_W'(3));
    // backspace mid-line and at column zero
    send_command(OP_PUT, CH_BS, '0);
    send_command(OP_READ, 8'h00, ADDR_W'(3));
    send_command(OP_PUT, CH_CR, '0);
    send_command(OP_PUT, CH_BS, '0);
    // tab from an odd column and from a tab stop
    send_command(OP_PUT, 8'h78, '0);
    send_command(OP_PUT, CH_TAB, '0);
    send_command(OP_PUT, CH_TAB, '0);
    send_command(OP_READ, 8'h00, ADDR_W'(12));
    send_command(OP_PUT, CH_LF, '0);
    send_command(OP_UNUSED, 8'hff, '1);
    send_command(OP_READ, 8'h00, ADDR_W'(0));
    // clear keeps the cursor
    send_command(OP_CLEAR, 8'h55, ADDR_W'(0));
    send_command(OP_READ, 8'h00, ADDR_W'(0));
    send_command(OP_READ, 8'h00, ADDR_W'(CELLS - 1));

    drain();
    write_attribute(8'hff);
    send_text(210);
    drain();
    write_attribute(8'h00);
    send_text(210);
    drain();
    write_attribute(ATTR_W'($urandom));
    send_text(210);
    drain();
    write_attribute(ATTR_W'($urandom));
    send_text(210);

    drain();
    repeat (2200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer.sv
tb/tcw_scoreboard_pkg.sv
tb/tb_top.sv
